@@ rtl/ric_pkg.sv @@
// Package for the reference-counted inode cache table.
// Holds sizes, field widths, status codes and the shared structs.
// No dependencies; every other file except ric_ram imports it.
package ric_pkg;

  localparam int ENTRIES          = 64;
  localparam int INODES_PER_BLOCK = 8;
  localparam int IDX_W            = $clog2(ENTRIES);

  localparam int DEV_W  = 4;
  localparam int INO_W  = 16;
  localparam int SLOT_W = 6;
  localparam int BLK_W  = 24;
  localparam int OFS_W  = 3;
  localparam int REF_W  = 8;
  localparam int ST_W   = 3;

  localparam logic [REF_W-1:0] REF_MAX  = {REF_W{1'b1}};
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_e;

  typedef enum logic [ST_W-1:0] {
    ST_HIT       = 3'd0,
    ST_ALLOC     = 3'd1,
    ST_FULL      = 3'd2,
    ST_HELD      = 3'd3,
    ST_CLEAN     = 3'd4,
    ST_WRITEBACK = 3'd5,
    ST_UNUSED    = 3'd6,
    ST_OVERFLOW  = 3'd7
  } status_e;

  // One table entry as stored in the entry RAM.
  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [INO_W-1:0] inode;
    logic [REF_W-1:0] refs;
    logic             dirty;
  } entry_t;

  // Write request toward the entry RAM.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } ram_wr_t;

  // One result transaction.
  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] entry;
    logic [BLK_W-1:0]  disk_block;
    logic [OFS_W-1:0]  block_offset;
    logic [REF_W-1:0]  references;
  } rsp_t;

endpackage

@@ rtl/ric_req_if.sv @@
// Request channel of the inode cache table: valid/ready plus the request fields.
// Depends on ric_pkg for the field widths.
interface ric_req_if import ric_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [DEV_W-1:0]  device;
  logic [INO_W-1:0]  inode_number;
  logic [SLOT_W-1:0] slot;
  logic              modified;

  modport source (output valid, kind, device, inode_number, slot, modified, input ready);
  modport sink   (input valid, kind, device, inode_number, slot, modified, output ready);
endinterface

@@ rtl/ric_rsp_if.sv @@
// Result channel of the inode cache table: valid/ready plus the result fields.
// Depends on ric_pkg for the field widths.
interface ric_rsp_if import ric_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [SLOT_W-1:0] entry;
  logic [BLK_W-1:0]  disk_block;
  logic [OFS_W-1:0]  block_offset;
  logic [REF_W-1:0]  references;

  modport source (output valid, status, entry, disk_block, block_offset, references,
                  input ready);
  modport sink   (input valid, status, entry, disk_block, block_offset, references,
                  output ready);
endinterface

@@ rtl/refcounted_inode_cache_table.sv @@
// Reference-counted inode cache table, top level.
// Depends on ric_pkg, ric_req_if, ric_rsp_if, ric_ram and ric_ctrl.
//
// Usage:
//   req_i carries one request per transaction: kind get (device, inode_number)
//   or kind put (slot, modified). rsp_o returns exactly one result transaction
//   per request: status, entry, disk_block, block_offset, references.
//   cfg_we_i/cfg_wdata_i write the first block of the on-disk inode table;
//   write it only while no request is outstanding.
//
// Sequencing:
//   One request is in work at a time; req_i.ready is high only while idle.
//   A get scans the entry RAM one word per cycle through a single compare
//   unit and stops at the first hit; a miss (allocate or full) scans every
//   entry. A put reads its slot once. Each result passes through S_DONE into
//   the output register, and the block returns to idle as it is registered.
//   A get's cost grows with the slot it scans to, set by the one-word-per-cycle
//   RAM read port.
//
// Reset clears all reference counts and dirty marks at once through a live
// bit per entry; no clearing pass is needed. The result sits in an output
// register: the next request is accepted while it waits, and if rsp_o stalls
// the block holds its following result until the register frees up.
module refcounted_inode_cache_table import ric_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [BLK_W-1:0] cfg_wdata_i,
  ric_req_if.sink          req_i,
  ric_rsp_if.source        rsp_o
);

  logic [BLK_W-1:0] table_start_q;
  logic [IDX_W-1:0] rd_addr;
  logic [$bits(entry_t)-1:0] rd_raw;
  entry_t           rd_word;
  ram_wr_t          wr;

  // Inode table base register; no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_start_q <= '0;
    end else if (cfg_we_i) begin
      table_start_q <= cfg_wdata_i;
    end
  end

  // Entry store: device, inode, count and dirty mark per slot.
  ric_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (rd_addr),
    .rdata_o (rd_raw)
  );

  assign rd_word = rd_raw;

  // Sequencer, compare unit, inode locator and result register.
  ric_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_i),
    .rsp_o         (rsp_o),
    .table_start_i (table_start_q),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_word),
    .wr_o          (wr)
  );

  // A full table reports nothing but the status.
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_FULL) |->
      (rsp_o.entry == '0 && rsp_o.references == '0 && rsp_o.disk_block == '0))
    else $error("full result carries data");

  // Block and offset only for a load or a writeback.
  a_loc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != ST_ALLOC && rsp_o.status != ST_WRITEBACK) |->
      (rsp_o.disk_block == '0 && rsp_o.block_offset == '0))
    else $error("block reported without load or writeback");

  // A fresh allocation starts with one reference.
  a_alloc_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_ALLOC) |-> (rsp_o.references == REF_W'(1)))
    else $error("allocation with count other than one");

  // Go busy right after taking a request.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("ready right after accepting a request");

endmodule

@@ rtl/ric_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependency.
module ric_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ric_cmp.sv @@
// Entry compare unit: masks a stored entry by its live bit and checks it
// against the requested device and inode. Depends on ric_pkg.
module ric_cmp import ric_pkg::*; (
  input  entry_t           word_i,
  input  logic             live_i,
  input  logic [DEV_W-1:0] device_i,
  input  logic [INO_W-1:0] inode_i,
  output logic             match_o,
  output logic             free_o,
  output logic [REF_W-1:0] refs_o
);

  // An entry never written since reset counts as free.
  assign refs_o  = live_i ? word_i.refs : '0;
  assign free_o  = (refs_o == '0);
  assign match_o = !free_o && (word_i.device == device_i) && (word_i.inode == inode_i);

endmodule

@@ rtl/ric_loc.sv @@
// Inode locator: disk block and offset within the block for an inode number.
// Depends on ric_pkg.
module ric_loc import ric_pkg::*; (
  input  logic [INO_W-1:0] inode_i,
  input  logic [BLK_W-1:0] start_i,
  output logic [BLK_W-1:0] block_o,
  output logic [OFS_W-1:0] offset_o
);

  logic [INO_W-1:0] idx;

  // Inode numbers count from one; zero wraps to the top of the range.
  assign idx      = inode_i - 1'b1;
  assign block_o  = BLK_W'(idx / INODES_PER_BLOCK) + start_i;
  assign offset_o = OFS_W'(idx % INODES_PER_BLOCK);

endmodule

@@ rtl/ric_ctrl.sv @@
// Sequencer of the inode cache table: walks the entry RAM one word a cycle
// through the shared compare unit, updates entries and holds the result.
// Depends on ric_pkg, ric_req_if, ric_rsp_if, ric_cmp and ric_loc.
module ric_ctrl import ric_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  ric_req_if.sink          req_i,
  ric_rsp_if.source        rsp_o,
  input  logic [BLK_W-1:0] table_start_i,
  output logic [IDX_W-1:0] rd_addr_o,
  input  entry_t           rd_data_i,
  output ram_wr_t          wr_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_PUT  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  chk_idx_q, chk_idx_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic              free_seen_q, free_seen_d;
  kind_e             kind_q;
  logic [DEV_W-1:0]  dev_q;
  logic [INO_W-1:0]  ino_q;
  logic [SLOT_W-1:0] slot_q;
  logic              mod_q;
  rsp_t              res_q, res_d;
  rsp_t              out_q;
  logic              out_valid_q;
  ram_wr_t           wr_q, wr_d;
  logic [ENTRIES-1:0] live_q;

  logic              accept;
  logic              emit;
  logic              match;
  logic              free;
  logic [REF_W-1:0]  refs;
  logic [REF_W-1:0]  new_refs;
  logic              new_dirty;
  logic              slot_ok;
  logic [INO_W-1:0]  loc_ino;
  logic [BLK_W-1:0]  loc_block;
  logic [OFS_W-1:0]  loc_offset;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign emit        = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);
  assign slot_ok     = int'(slot_q) < ENTRIES;

  ric_cmp u_cmp (
    .word_i   (rd_data_i),
    .live_i   (live_q[chk_idx_q]),
    .device_i (dev_q),
    .inode_i  (ino_q),
    .match_o  (match),
    .free_o   (free),
    .refs_o   (refs)
  );

  // A get loads its own inode; a writeback uses the stored one.
  assign loc_ino = (kind_q == KIND_PUT) ? rd_data_i.inode : ino_q;

  ric_loc u_loc (
    .inode_i  (loc_ino),
    .start_i  (table_start_i),
    .block_o  (loc_block),
    .offset_o (loc_offset)
  );

  assign new_refs  = refs - 1'b1;
  assign new_dirty = rd_data_i.dirty | mod_q;

  // During a scan, read one address ahead of the word under compare.
  always_comb begin
    case (state_q)
      S_IDLE:  rd_addr_o = (req_i.kind == KIND_PUT) ? IDX_W'(req_i.slot) : '0;
      S_SCAN:  rd_addr_o = chk_idx_q + 1'b1;
      default: rd_addr_o = chk_idx_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    chk_idx_d   = chk_idx_q;
    free_idx_d  = free_idx_q;
    free_seen_d = free_seen_q;
    res_d       = res_q;
    wr_d.en     = 1'b0;
    wr_d.addr   = chk_idx_q;
    wr_d.data   = rd_data_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          free_seen_d = 1'b0;
          if (req_i.kind == KIND_PUT) begin
            chk_idx_d = IDX_W'(req_i.slot);
            state_d   = S_PUT;
          end else begin
            chk_idx_d = '0;
            state_d   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        chk_idx_d = chk_idx_q + 1'b1;
        if (match) begin
          res_d       = '0;
          res_d.entry = SLOT_W'(chk_idx_q);
          if (refs == REF_MAX) begin
            res_d.status     = ST_OVERFLOW;
            res_d.references = REF_MAX;
          end else begin
            res_d.status     = ST_HIT;
            res_d.references = refs + 1'b1;
            wr_d.en          = 1'b1;
            wr_d.data.refs   = refs + 1'b1;
          end
          state_d = S_DONE;
        end else begin
          // Remember the lowest free slot on the way.
          if (free && !free_seen_q) begin
            free_seen_d = 1'b1;
            free_idx_d  = chk_idx_q;
          end
          if (chk_idx_q == LAST_IDX) begin
            res_d = '0;
            if (free_seen_d) begin
              res_d.status       = ST_ALLOC;
              res_d.entry        = SLOT_W'(free_idx_d);
              res_d.disk_block   = loc_block;
              res_d.block_offset = loc_offset;
              res_d.references   = REF_W'(1);
              wr_d.en            = 1'b1;
              wr_d.addr          = free_idx_d;
              wr_d.data          = '{device: dev_q, inode: ino_q, refs: REF_W'(1),
                                     dirty: 1'b0};
            end else begin
              res_d.status = ST_FULL;
            end
            state_d = S_DONE;
          end
        end
      end
      S_PUT: begin
        res_d       = '0;
        res_d.entry = slot_q;
        if (!slot_ok || refs == '0) begin
          res_d.status = ST_UNUSED;
        end else begin
          res_d.references = new_refs;
          wr_d.en          = 1'b1;
          wr_d.data.refs   = new_refs;
          wr_d.data.dirty  = new_dirty;
          if (new_refs != '0) begin
            res_d.status = ST_HELD;
          end else if (new_dirty) begin
            res_d.status       = ST_WRITEBACK;
            res_d.disk_block   = loc_block;
            res_d.block_offset = loc_offset;
          end else begin
            res_d.status = ST_CLEAN;
          end
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_seen_q <= 1'b0;
      out_valid_q <= 1'b0;
      wr_q        <= '0;
      live_q      <= '0;
    end else begin
      state_q     <= state_d;
      free_seen_q <= free_seen_d;
      wr_q        <= wr_d;
      if (wr_q.en) begin
        live_q[wr_q.addr] <= 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
    if (accept) begin
      kind_q <= kind_e'(req_i.kind);
      dev_q  <= req_i.device;
      ino_q  <= req_i.inode_number;
      slot_q <= req_i.slot;
      mod_q  <= req_i.modified;
    end
    if (emit) begin
      out_q <= res_q;
    end
  end

  assign wr_o = wr_q;

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.entry        = out_q.entry;
  assign rsp_o.disk_block   = out_q.disk_block;
  assign rsp_o.block_offset = out_q.block_offset;
  assign rsp_o.references   = out_q.references;

endmodule
